### design/assert_macros.svh
// assertion macros shared by the uart line ring buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while reset is high
`define ULRB_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true at a clock edge
`define ULRB_ASSERT_NEVER(label, clk, rst, cond, msg) \
  `ULRB_ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

### design/ulrb_pkg.sv
// types and constants of the uart line ring buffers
`default_nettype none

package ulrb_pkg;

  // action codes
  localparam logic [2:0] ACT_RX_BYTE   = 3'd0;
  localparam logic [2:0] ACT_GET_CHAR  = 3'd1;
  localparam logic [2:0] ACT_GET_LINE  = 3'd2;
  localparam logic [2:0] ACT_PUT_CHAR  = 3'd3;
  localparam logic [2:0] ACT_TX_SLOT   = 3'd4;

  // line terminators stored as zero
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // saturation value of the line count
  localparam logic [7:0] LINE_COUNT_MAX = 8'hFF;

  // results of one line read, the forced final one included; data results stop one below
  localparam int unsigned MAX_RESULTS   = 64;
  localparam int unsigned LINE_CNT_W    = $clog2(MAX_RESULTS);
  localparam logic [LINE_CNT_W-1:0] LINE_DATA_MAX = LINE_CNT_W'(MAX_RESULTS - 1);

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rx_dropped;
    logic       tx_dropped;
    logic [7:0] lines_pending;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

### design/ulrb_ram.sv
// generic simple dual port ram with one write port and a registered read port
`default_nettype none

module ulrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/uart_line_ring_buffers_unit.sv
// top level of the uart line ring buffers: rx and tx rings in ram with host access
// The unit keeps an RX ring of RX_DEPTH-1 bytes and a TX ring of TX_DEPTH-1 bytes,
// each in a synchronous RAM with a registered read port. One item is worked on at
// a time. A received byte, a put char and an unknown action give their one result
// directly. A get char or a tx slot that finds its ring non-empty first waits on the
// RAM read and then gives its result; on an empty ring it gives it directly. A get
// line with a line pending is accepted, then every popped byte, the terminator
// included, takes a RAM read and then a result; when the ring runs empty or 63 data
// results have been given, a final zero result follows. A get line with no line
// pending gives its result directly. A result that waits for out_ready holds the
// item back. Every result sits in one output register, so a new item is taken while
// the last result of the previous one is being transferred.
`default_nettype none

`include "assert_macros.svh"

module uart_line_ring_buffers_unit #(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ulrb_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ulrb_pkg::out_t      out_data
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_TX,
    S_LINE_RD,
    S_LINE_DATA
  } state_t;

  state_t                        state;
  logic [RX_AW-1:0]              rx_head;
  logic [RX_AW-1:0]              rx_tail;
  logic [TX_AW-1:0]              tx_head;
  logic [TX_AW-1:0]              tx_tail;
  logic [7:0]                    line_count;
  logic [ulrb_pkg::LINE_CNT_W-1:0] line_cnt;

  logic [RX_AW-1:0] rx_head_inc;
  logic [RX_AW-1:0] rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc;
  logic [TX_AW-1:0] tx_tail_inc;
  logic             rx_empty;
  logic             rx_full;
  logic             tx_empty;
  logic             tx_full;
  logic             can_emit;
  logic             in_xfer;
  logic             is_eol;
  logic             line_more;
  logic             out_load;
  logic             rx_we;
  logic [7:0]       rx_wdata;
  logic             rx_rd_en;
  logic [7:0]       rx_rdata;
  logic             tx_we;
  logic             tx_rd_en;
  logic [7:0]       tx_rdata;
  logic [7:0]       line_count_rx;

  // pack one result
  function automatic ulrb_pkg::out_t make_result(
    input logic [7:0] rc,
    input logic [7:0] txb,
    input logic       txv,
    input logic       rxd,
    input logic       txd,
    input logic [7:0] lp,
    input logic       lst
  );
    ulrb_pkg::out_t r;
    r.read_char     = rc;
    r.tx_byte       = txb;
    r.tx_valid      = txv;
    r.rx_dropped    = rxd;
    r.tx_dropped    = txd;
    r.lines_pending = lp;
    r.last          = lst;
    return r;
  endfunction

  // ring pointer arithmetic and occupancy
  always_comb begin
    rx_head_inc = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
    rx_tail_inc = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
    tx_head_inc = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
    tx_tail_inc = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
    rx_empty    = (rx_head == rx_tail);
    rx_full     = (rx_head_inc == rx_tail);
    tx_empty    = (tx_head == tx_tail);
    tx_full     = (tx_head_inc == tx_tail);
  end

  // handshake and ram control
  always_comb begin
    can_emit  = !out_valid || out_ready;
    in_ready  = (state == S_IDLE) && can_emit;
    in_xfer   = in_valid && in_ready;
    is_eol    = (in_data.data_byte == ulrb_pkg::CHAR_CR) ||
                (in_data.data_byte == ulrb_pkg::CHAR_LF);
    line_more = !rx_empty && (line_cnt != ulrb_pkg::LINE_DATA_MAX);
    rx_we     = in_xfer && (in_data.action == ulrb_pkg::ACT_RX_BYTE) && !rx_full;
    rx_wdata  = is_eol ? 8'h00 : in_data.data_byte;
    rx_rd_en  = (in_xfer && (in_data.action == ulrb_pkg::ACT_GET_CHAR) && !rx_empty) ||
                ((state == S_LINE_RD) && line_more);
    tx_we     = in_xfer && (in_data.action == ulrb_pkg::ACT_PUT_CHAR) && !tx_full;
    tx_rd_en  = in_xfer && (in_data.action == ulrb_pkg::ACT_TX_SLOT) && !tx_empty;
    line_count_rx = (rx_we && is_eol && (line_count != ulrb_pkg::LINE_COUNT_MAX)) ?
                    line_count + 8'd1 : line_count;
    // a result enters the output register this cycle
    out_load  = (in_xfer &&
                 !((in_data.action == ulrb_pkg::ACT_GET_CHAR) && !rx_empty) &&
                 !((in_data.action == ulrb_pkg::ACT_GET_LINE) && (line_count != 8'd0)) &&
                 !((in_data.action == ulrb_pkg::ACT_TX_SLOT) && !tx_empty)) ||
                (state == S_CHAR) || (state == S_TX) ||
                ((state == S_LINE_RD) && !line_more && can_emit) ||
                ((state == S_LINE_DATA) && can_emit);
  end

  // rx byte store
  ulrb_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_inc),
    .wdata (rx_wdata),
    .re    (rx_rd_en),
    .raddr (rx_tail_inc),
    .rdata (rx_rdata)
  );

  // tx byte store
  ulrb_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_inc),
    .wdata (in_data.data_byte),
    .re    (tx_rd_en),
    .raddr (tx_tail_inc),
    .rdata (tx_rdata)
  );

  // state machine, ring pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rx_head    <= '0;
      rx_tail    <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      line_count <= '0;
      line_cnt   <= '0;
    end else begin
      // set on a load, cleared once the result is transferred
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rx_we) begin
        rx_head <= rx_head_inc;
      end
      if (rx_rd_en) begin
        rx_tail <= rx_tail_inc;
      end
      if (tx_we) begin
        tx_head <= tx_head_inc;
      end
      if (tx_rd_en) begin
        tx_tail <= tx_tail_inc;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_data.action)
              ulrb_pkg::ACT_RX_BYTE: begin
                line_count <= line_count_rx;
                out_data   <= make_result(8'h00, 8'h00, 1'b0, rx_full, 1'b0,
                                          line_count_rx, 1'b1);
              end
              ulrb_pkg::ACT_GET_CHAR: begin
                if (rx_empty) begin
                  out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                                           line_count, 1'b1);
                end else begin
                  state <= S_CHAR;
                end
              end
              ulrb_pkg::ACT_GET_LINE: begin
                if (line_count == 8'd0) begin
                  out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                                           line_count, 1'b1);
                end else begin
                  line_count <= line_count - 8'd1;
                  line_cnt   <= '0;
                  state      <= S_LINE_RD;
                end
              end
              ulrb_pkg::ACT_PUT_CHAR: begin
                out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, tx_full,
                                         line_count, 1'b1);
              end
              ulrb_pkg::ACT_TX_SLOT: begin
                if (tx_empty) begin
                  out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                                           line_count, 1'b1);
                end else begin
                  state <= S_TX;
                end
              end
              default: begin
                out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                                         line_count, 1'b1);
              end
            endcase
          end
        end
        // output register is free here: the item was taken with the slot draining
        S_CHAR: begin
          out_data  <= make_result(rx_rdata, 8'h00, 1'b0, 1'b0, 1'b0, line_count, 1'b1);
          state     <= S_IDLE;
        end
        S_TX: begin
          out_data  <= make_result(8'h00, tx_rdata, 1'b1, 1'b0, 1'b0, line_count, 1'b1);
          state     <= S_IDLE;
        end
        // issue the next pop, or close the line when empty or at the result limit
        S_LINE_RD: begin
          if (line_more) begin
            state <= S_LINE_DATA;
          end else if (can_emit) begin
            out_data  <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, line_count, 1'b1);
            state     <= S_IDLE;
          end
        end
        // popped byte is held by the ram until the output register frees up
        S_LINE_DATA: begin
          if (can_emit) begin
            if (rx_rdata == 8'h00) begin
              out_data <= make_result(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, line_count, 1'b1);
              state    <= S_IDLE;
            end else begin
              out_data <= make_result(rx_rdata, 8'h00, 1'b0, 1'b0, 1'b0, line_count, 1'b0);
              line_cnt <= line_cnt + 1'b1;
              state    <= S_LINE_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `ULRB_ASSERT_NEVER(a_rx_pop_empty, clk, rst, rx_rd_en && rx_empty, "rx pop from empty ring")
  `ULRB_ASSERT_NEVER(a_tx_pop_empty, clk, rst, tx_rd_en && tx_empty, "tx pop from empty ring")
  `ULRB_ASSERT_NEVER(a_rx_rw_overlap, clk, rst, rx_we && rx_rd_en, "rx write during rx read")
  `ULRB_ASSERT_NEVER(a_line_zero_data, clk, rst,
    out_valid && !out_data.last && (out_data.read_char == 8'h00), "zero byte as line data")
  `ULRB_ASSERT_CLK(a_count_sat, clk, rst,
    (line_count == ulrb_pkg::LINE_COUNT_MAX) &&
    !(in_xfer && (in_data.action == ulrb_pkg::ACT_GET_LINE)) |=>
    (line_count == ulrb_pkg::LINE_COUNT_MAX), "line count wrapped")

endmodule

`default_nettype wire
